@@ sv/lirs_pkg.sv @@
package lirs_pkg;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_START,
        ST_LOOP,
        ST_DIV,
        ST_MUL,
        ST_REL,
        ST_ELOOP,
        ST_RELF,
        ST_FINISH
    } state_t;

    // What the shared divider or multiplier is working on
    typedef enum logic [2:0] {
        OP_REDUCE,
        OP_FRAC,
        OP_PROD,
        OP_STEP,
        OP_NT,
        OP_TOTAL
    } op_t;

    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    localparam int TARGET_RESET = 16000;
    localparam int RESULT_CAP   = 64;
    localparam int CNT_BITS     = 32;

endpackage

@@ sv/linear_interpolating_resampler.sv @@
// Passthrough or ratio-error words pass after acceptance through the ST_SINGLE state into the output register.
// Interpolated words are computed by the bit-serial divider and multiplier.
// A stream-end word also computes the total count, n * target / source, multiply first.
// One input word is processed at a time; s_ready is high only when idle.
// Reset (aresetn low, synchronous): rates go to 0 / 16000, stream state clears.
module linear_interpolating_resampler
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int RATE_BITS     = 19,
    parameter int MAX_UPSAMPLE  = 31,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic                   cfg_addr,
    input  logic [RATE_BITS-1:0]   cfg_wr_data,
    // input words
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                   s_stream_end,
    // result words
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_sample_out,
    output logic                   m_run_last,
    output logic                   m_stream_done,
    output logic                   m_ratio_error
);

    localparam int SB    = SAMPLE_BITS;
    localparam int RB    = RATE_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int PH_W  = RB + 1;               // phase plus one source step
    localparam int N_W   = CNT_BITS + 1;         // input count plus one, unwrapped
    localparam int DW    = N_W + RB;             // widest dividend: n * target
    localparam int PW    = SB + 1 + F;           // interpolation product
    localparam int MW    = (DW > PW) ? DW : PW;  // multiplier accumulator
    localparam int MLW   = (F > RB) ? F : RB;    // multiplier operand shifter
    localparam int UC_W  = $clog2(DW + 1);
    localparam int G_W   = $clog2(RESULT_CAP + 1);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [RB-1:0]       src_rate_reg, src_rate_next;
    logic [RB-1:0]       tgt_rate_reg, tgt_rate_next;
    logic [SB-1:0]       smp_reg, smp_next;
    logic                end_reg, end_next;
    logic                sgl_err_reg, sgl_err_next;
    logic [SB-1:0]       prev_reg, prev_next;
    logic [PH_W-1:0]     phase_reg, phase_next;
    logic [CNT_BITS-1:0] srcpos_reg, srcpos_next;
    logic [CNT_BITS-1:0] rcvd_reg, rcvd_next;
    logic [CNT_BITS-1:0] rel_reg, rel_next;
    logic [N_W-1:0]      n_reg, n_next;
    logic [SB-1:0]       held_reg, held_next;
    logic                held_vld_reg, held_vld_next;
    logic [SB-1:0]       cand_reg, cand_next;
    logic [SB-1:0]       pend_reg, pend_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [G_W-1:0]      rescnt_reg, rescnt_next;
    logic [G_W-1:0]      guard_reg, guard_next;
    logic                endph_reg, endph_next;
    logic [DW-1:0]       total_reg, total_next;
    logic [UC_W-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]       dvd_reg, dvd_next;
    logic [RB-1:0]       rem_reg, rem_next;
    logic [RB-1:0]       den_reg, den_next;
    logic [MW-1:0]       acc_reg, acc_next;
    logic [MW-1:0]       mcand_reg, mcand_next;
    logic [MLW-1:0]      mplr_reg, mplr_next;
    logic                out_vld_reg, out_vld_next;
    logic [SB-1:0]       out_smp_reg, out_smp_next;
    logic                out_last_reg, out_last_next;
    logic                out_done_reg, out_done_next;
    logic                out_err_reg, out_err_next;

    logic            in_acc;
    logic            out_free;
    logic            is_pass;
    logic            is_err;
    logic [RB+4:0]   up_limit;
    logic [RB:0]     rem_shift;
    logic            div_ge;
    logic [SB:0]     diff;
    logic [PW-1:0]   prod_rnd;
    logic [SB:0]     step_val;
    logic [SB:0]     interp;
    logic [N_W-1:0]  n_cur;
    logic            rel_emit;
    logic            rel_store;
    logic            rel_stall;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !out_vld_reg || m_ready;

    assign up_limit = (RB+5)'(src_rate_reg) * (RB+5)'(MAX_UPSAMPLE);
    assign is_pass  = (src_rate_reg == '0) || (tgt_rate_reg == '0)
                      || (src_rate_reg == tgt_rate_reg);
    assign is_err   = (RB+5)'(tgt_rate_reg) > up_limit;

    // one restoring division step
    assign rem_shift = {rem_reg, dvd_reg[DW-1]};
    assign div_ge    = rem_shift >= {1'b0, den_reg};

    // interpolation: a + round(prod / 2^F), ties up
    assign diff     = {smp_reg[SB-1], smp_reg} - {prev_reg[SB-1], prev_reg};
    assign prod_rnd = acc_reg[PW-1:0] + (PW'(1) << (F - 1));
    assign step_val = prod_rnd[PW-1:F];
    assign interp   = {prev_reg[SB-1], prev_reg} + step_val;

    assign n_cur = {1'b0, rcvd_reg} + N_W'(1);

    // release of the held candidate; at stream end only up to the total
    assign rel_emit  = held_vld_reg && (!endph_reg || (DW'(rel_reg) < total_reg));
    assign rel_store = rel_emit && (rescnt_reg < G_W'(RESULT_CAP));
    assign rel_stall = rel_store && pend_vld_reg && !out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (is_pass || is_err) ? ST_SINGLE : ST_START;
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_START: begin
                state_next = (phase_reg >= PH_W'(tgt_rate_reg)) ? ST_DIV : ST_LOOP;
            end
            ST_LOOP: begin
                if ((srcpos_reg < rcvd_reg) && (guard_reg < G_W'(RESULT_CAP))) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = end_reg ? ST_MUL : ST_FINISH;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    unique case (op_reg)
                        OP_REDUCE: state_next = ST_LOOP;
                        OP_FRAC:   state_next = ST_MUL;
                        OP_STEP:   state_next = endph_reg ? ST_ELOOP : ST_LOOP;
                        OP_TOTAL:  state_next = ST_ELOOP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                if (cnt_reg == '0) begin
                    state_next = (op_reg == OP_PROD) ? ST_REL : ST_DIV;
                end
            end
            ST_REL: begin
                if (!rel_stall) begin
                    state_next = ST_DIV;
                end
            end
            ST_ELOOP: begin
                if (({1'b0, srcpos_reg} < n_reg) && (guard_reg < G_W'(RESULT_CAP))) begin
                    state_next = ST_REL;
                end else begin
                    state_next = ST_RELF;
                end
            end
            ST_RELF: begin
                if (!rel_stall) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!pend_vld_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        m_valid       = out_vld_reg;
        m_sample_out  = out_smp_reg;
        m_run_last    = out_last_reg;
        m_stream_done = out_done_reg;
        m_ratio_error = out_err_reg;
    end

    // datapath
    always_comb begin
        op_next       = op_reg;
        src_rate_next = src_rate_reg;
        tgt_rate_next = tgt_rate_reg;
        smp_next      = smp_reg;
        end_next      = end_reg;
        sgl_err_next  = sgl_err_reg;
        prev_next     = prev_reg;
        phase_next    = phase_reg;
        srcpos_next   = srcpos_reg;
        rcvd_next     = rcvd_reg;
        rel_next      = rel_reg;
        n_next        = n_reg;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        cand_next     = cand_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        rescnt_next   = rescnt_reg;
        guard_next    = guard_reg;
        endph_next    = endph_reg;
        total_next    = total_reg;
        cnt_next      = cnt_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplr_next     = mplr_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        out_smp_next  = out_smp_reg;
        out_last_next = out_last_reg;
        out_done_next = out_done_reg;
        out_err_next  = out_err_reg;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SOURCE: src_rate_next = cfg_wr_data;
                REG_TARGET: tgt_rate_next = cfg_wr_data;
                default:    src_rate_next = src_rate_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    smp_next     = s_sample_in;
                    end_next     = s_stream_end;
                    sgl_err_next = !is_pass && is_err;
                    rescnt_next  = '0;
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_smp_next  = sgl_err_reg ? '0 : smp_reg;
                    out_last_next = 1'b1;
                    out_done_next = end_reg;
                    out_err_next  = sgl_err_reg;
                end
            end
            ST_START: begin
                guard_next = '0;
                endph_next = 1'b0;
                op_next    = OP_REDUCE;
                dvd_next   = DW'(phase_reg) << (DW - PH_W);
                rem_next   = '0;
                den_next   = tgt_rate_reg;
                cnt_next   = UC_W'(PH_W);
            end
            ST_LOOP: begin
                if ((srcpos_reg < rcvd_reg) && (guard_reg < G_W'(RESULT_CAP))) begin
                    // fraction = phase * 2^F / target
                    op_next  = OP_FRAC;
                    dvd_next = DW'(phase_reg) << (DW - PH_W);
                    rem_next = '0;
                    den_next = tgt_rate_reg;
                    cnt_next = UC_W'(PH_W + F);
                end else begin
                    prev_next = smp_reg;
                    rcvd_next = rcvd_reg + CNT_BITS'(1);
                    n_next    = n_cur;
                    if (end_reg) begin
                        // total = n * target / source, multiply first
                        endph_next = 1'b1;
                        op_next    = OP_NT;
                        acc_next   = '0;
                        mcand_next = MW'(n_cur);
                        mplr_next  = MLW'(tgt_rate_reg) << (MLW - RB);
                        cnt_next   = UC_W'(RB);
                    end
                end
            end
            ST_DIV: begin
                if (cnt_reg != '0) begin
                    rem_next = div_ge ? RB'(rem_shift - {1'b0, den_reg}) : RB'(rem_shift);
                    dvd_next = {dvd_reg[DW-2:0], div_ge};
                    cnt_next = cnt_reg - UC_W'(1);
                end else begin
                    unique case (op_reg)
                        OP_REDUCE: phase_next = {1'b0, rem_reg};
                        OP_FRAC: begin
                            op_next    = OP_PROD;
                            acc_next   = '0;
                            mcand_next = {{(MW-SB-1){diff[SB]}}, diff};
                            mplr_next  = MLW'(dvd_reg[F-1:0]) << (MLW - F);
                            cnt_next   = UC_W'(F);
                        end
                        OP_STEP: begin
                            phase_next  = {1'b0, rem_reg};
                            srcpos_next = srcpos_reg + CNT_BITS'(dvd_reg[PH_W-1:0]);
                            guard_next  = guard_reg + G_W'(1);
                        end
                        OP_TOTAL: begin
                            total_next = (dvd_reg == '0) ? DW'(1) : dvd_reg;
                            guard_next = '0;
                        end
                        default: phase_next = phase_reg;
                    endcase
                end
            end
            ST_MUL: begin
                if (cnt_reg != '0) begin
                    acc_next  = (acc_reg << 1) + (mplr_reg[MLW-1] ? mcand_reg : '0);
                    mplr_next = mplr_reg << 1;
                    cnt_next  = cnt_reg - UC_W'(1);
                end else if (op_reg == OP_PROD) begin
                    cand_next = interp[SB-1:0];
                end else begin
                    op_next  = OP_TOTAL;
                    dvd_next = acc_reg[DW-1:0];
                    rem_next = '0;
                    den_next = src_rate_reg;
                    cnt_next = UC_W'(DW);
                end
            end
            ST_REL: begin
                if (!rel_stall) begin
                    if (rel_store) begin
                        if (pend_vld_reg) begin
                            out_vld_next  = 1'b1;
                            out_smp_next  = pend_reg;
                            out_last_next = 1'b0;
                            out_done_next = 1'b0;
                            out_err_next  = 1'b0;
                        end
                        pend_next     = held_reg;
                        pend_vld_next = 1'b1;
                        rescnt_next   = rescnt_reg + G_W'(1);
                    end
                    if (rel_emit) begin
                        rel_next = rel_reg + CNT_BITS'(1);
                    end
                    held_next     = cand_reg;
                    held_vld_next = 1'b1;
                    // advance the phase by one source step
                    op_next  = OP_STEP;
                    dvd_next = DW'(phase_reg + PH_W'(src_rate_reg)) << (DW - PH_W);
                    rem_next = '0;
                    den_next = tgt_rate_reg;
                    cnt_next = UC_W'(PH_W);
                end
            end
            ST_ELOOP: begin
                // right neighbour clamps to the last sample
                cand_next = smp_reg;
            end
            ST_RELF: begin
                if (!rel_stall) begin
                    if (rel_store) begin
                        if (pend_vld_reg) begin
                            out_vld_next  = 1'b1;
                            out_smp_next  = pend_reg;
                            out_last_next = 1'b0;
                            out_done_next = 1'b0;
                            out_err_next  = 1'b0;
                        end
                        pend_next     = held_reg;
                        pend_vld_next = 1'b1;
                        rescnt_next   = rescnt_reg + G_W'(1);
                    end
                    if (rel_emit) begin
                        rel_next = rel_reg + CNT_BITS'(1);
                    end
                    held_vld_next = 1'b0;
                end
            end
            ST_FINISH: begin
                if (pend_vld_reg && out_free) begin
                    out_vld_next  = 1'b1;
                    out_smp_next  = pend_reg;
                    out_last_next = 1'b1;
                    out_done_next = end_reg;
                    out_err_next  = 1'b0;
                    pend_vld_next = 1'b0;
                end
            end
            default: op_next = op_reg;
        endcase

        // drop the stream position state once the final word of a stream-end input is handled
        if (((state_reg == ST_SINGLE) && out_free)
            || ((state_reg == ST_FINISH) && (!pend_vld_reg || out_free))) begin
            if (end_reg) begin
                prev_next     = '0;
                phase_next    = '0;
                srcpos_next   = '0;
                rcvd_next     = '0;
                rel_next      = '0;
                held_next     = '0;
                held_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            src_rate_reg <= '0;
            tgt_rate_reg <= RB'(TARGET_RESET);
            prev_reg     <= '0;
            phase_reg    <= '0;
            srcpos_reg   <= '0;
            rcvd_reg     <= '0;
            rel_reg      <= '0;
            held_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            src_rate_reg <= src_rate_next;
            tgt_rate_reg <= tgt_rate_next;
            prev_reg     <= prev_next;
            phase_reg    <= phase_next;
            srcpos_reg   <= srcpos_next;
            rcvd_reg     <= rcvd_next;
            rel_reg      <= rel_next;
            held_vld_reg <= held_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        smp_reg      <= smp_next;
        end_reg      <= end_next;
        sgl_err_reg  <= sgl_err_next;
        n_reg        <= n_next;
        held_reg     <= held_next;
        cand_reg     <= cand_next;
        pend_reg     <= pend_next;
        rescnt_reg   <= rescnt_next;
        guard_reg    <= guard_next;
        endph_reg    <= endph_next;
        total_reg    <= total_next;
        cnt_reg      <= cnt_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplr_reg     <= mplr_next;
        out_smp_reg  <= out_smp_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
        out_err_reg  <= out_err_next;
    end

endmodule
